### sv/sfd_pkg.sv
// Shared types, constants and the CRC-16/Modbus byte update for the frame deframer.
// Used by sfd_parser, sync_frame_deframer_crc16 and sfd_checker; depends on nothing else.
package sfd_pkg;

    // Frame markers and CRC settings
    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'hBB;
    localparam logic [7:0]  END_MARK    = 8'hED;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    // Configuration register map
    localparam int          PADDR_W           = 3;
    localparam logic        REG_IDX_MAX_LEN   = 1'b0;
    localparam logic [15:0] MAX_LEN_RESET     = 16'd256;

    // Result kinds
    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    // Frame status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CRC_ERR   = 2'd1,
        ST_BAD_END   = 2'd2,
        ST_TOO_LONG  = 2'd3
    } sfd_status_t;

    // Parse phases, one-hot
    typedef enum logic [8:0] {
        PH_SYNC1   = 9'b000000001,
        PH_SYNC2   = 9'b000000010,
        PH_CMD     = 9'b000000100,
        PH_LENH    = 9'b000001000,
        PH_LENL    = 9'b000010000,
        PH_PAYLOAD = 9'b000100000,
        PH_CRCH    = 9'b001000000,
        PH_CRCL    = 9'b010000000,
        PH_END     = 9'b100000000
    } sfd_phase_t;

    // One result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        sfd_status_t status;
        logic [7:0]  command;
        logic [15:0] length;
    } sfd_result_t;

    // Fold one byte into a reflected CRC-16 (eight shift steps)
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### sv/sfd_parser.sv
// Frame parser state: phase, held header fields, payload count and running CRC.
// Depends on sfd_pkg; instantiated by sync_frame_deframer_crc16.
module sfd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          step_byte,
    input  logic [15:0]         max_len,
    output logic                res_valid,
    output sfd_pkg::sfd_result_t res
);
    import sfd_pkg::*;

    sfd_phase_t  phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic [15:0] crc_fed;
    logic [15:0] count_inc;
    logic [15:0] len_full;

    assign crc_fed   = crc16_byte(crc_reg, step_byte);
    assign count_inc = count_reg + 16'd1;
    assign len_full  = {len_reg[15:8], step_byte};

    // Next state and result for the byte at hand
    always_comb
    begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        rx_crc_next = rx_crc_reg;
        res_valid   = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = 8'h00;
        res.status       = ST_OK;

        case (phase_reg)
            PH_SYNC2:
            begin
                if (step_byte == SYNC_SECOND)
                begin
                    crc_next   = crc_fed;
                    phase_next = PH_CMD;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_CMD:
            begin
                cmd_next   = step_byte;
                crc_next   = crc_fed;
                phase_next = PH_LENH;
            end
            PH_LENH:
            begin
                len_next   = {step_byte, 8'h00};
                crc_next   = crc_fed;
                phase_next = PH_LENL;
            end
            PH_LENL:
            begin
                len_next = len_full;
                crc_next = crc_fed;
                if (len_full > max_len)
                begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_FRAME_END;
                    res.status = ST_TOO_LONG;
                    phase_next = PH_SYNC1;
                end
                else
                begin
                    count_next = 16'd0;
                    phase_next = (len_full != 16'd0) ? PH_PAYLOAD : PH_CRCH;
                end
            end
            PH_PAYLOAD:
            begin
                crc_next         = crc_fed;
                count_next       = count_inc;
                res_valid        = 1'b1;
                res.payload_byte = step_byte;
                if (count_inc >= len_reg)
                    phase_next = PH_CRCH;
            end
            PH_CRCH:
            begin
                rx_crc_next = {step_byte, 8'h00};
                phase_next  = PH_CRCL;
            end
            PH_CRCL:
            begin
                rx_crc_next = {rx_crc_reg[15:8], step_byte};
                phase_next  = PH_END;
            end
            PH_END:
            begin
                res_valid = 1'b1;
                res.kind  = KIND_FRAME_END;
                if (step_byte != END_MARK)
                    res.status = ST_BAD_END;
                else if (rx_crc_reg == crc_reg)
                    res.status = ST_OK;
                else
                    res.status = ST_CRC_ERR;
                phase_next = PH_SYNC1;
            end
            default:
            begin
                // Hunt for the first sync byte
                if (step_byte == SYNC_FIRST)
                begin
                    crc_next   = crc16_byte(CRC_INIT, step_byte);
                    phase_next = PH_SYNC2;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
        endcase

        res.command = cmd_reg;
        res.length  = len_next;
    end

    // Advance the parser on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SYNC1;
            cmd_reg    <= 8'h00;
            len_reg    <= 16'h0000;
            count_reg  <= 16'h0000;
            crc_reg    <= CRC_INIT;
            rx_crc_reg <= 16'h0000;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            rx_crc_reg <= rx_crc_next;
        end
    end

endmodule

### sv/sync_frame_deframer_crc16.sv
// Top level of the sync frame deframer with CRC-16/Modbus check.
// Depends on sfd_pkg and sfd_parser.
//
// Usage:
//   Received bytes enter on data_byte with byte_valid/byte_ready. Results leave
//   on result_valid/result_ready: a payload item (result_kind 0) for every
//   payload byte, and a frame-end item (result_kind 1) with frame_status,
//   frame_command and frame_length when a frame closes or its length exceeds
//   max_payload_len. Frames whose second sync byte is wrong produce nothing.
//   max_payload_len sits at APB addr 0-3 (reset 256); write it only while idle.
// Timing:
//   A byte accepted into the input register is run through the parser and its
//   result is loaded into the result register. One byte per cycle is sustained
//   while result_ready stays high; a byte's CRC update is an eight-step shift
//   chain evaluated between the input register and the parser's CRC register.
// Reset and stalls:
//   Reset returns the parser to the hunt for the first sync byte and clears the
//   running CRC to 0xFFFF. When the receiver holds result_ready low, the result
//   register holds its item and one more byte waits in the input register;
//   after that byte_ready drops until the result is taken.
module sync_frame_deframer_crc16 (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sfd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Byte input
    input  logic                        byte_valid,
    output logic                        byte_ready,
    input  logic [7:0]                  data_byte,
    // Result output
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic                        result_kind,
    output logic [7:0]                  payload_byte,
    output logic [1:0]                  frame_status,
    output logic [7:0]                  frame_command,
    output logic [15:0]                 frame_length
);
    import sfd_pkg::*;

    logic [15:0] max_len_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    sfd_result_t out_reg;
    logic        advance;
    logic        step_valid;
    sfd_result_t step_res;
    logic        cfg_wr;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg_wr && (paddr[PADDR_W-1] == REG_IDX_MAX_LEN))
            max_len_reg <= pwdata[15:0];
    end

    assign prdata = (paddr[PADDR_W-1] == REG_IDX_MAX_LEN) ? {16'h0000, max_len_reg} : 32'h0;

    // Move the held byte on when the result register can take its outcome
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign byte_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (byte_ready)
            in_valid_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            in_byte_reg <= data_byte;
    end

    sfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .step_byte (in_byte_reg),
        .max_len   (max_len_reg),
        .res_valid (step_valid),
        .res       (step_res)
    );

    // Result register: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= step_valid;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_valid)
            out_reg <= step_res;
    end

    assign result_valid  = out_valid_reg;
    assign result_kind   = out_reg.kind;
    assign payload_byte  = out_reg.payload_byte;
    assign frame_status  = out_reg.status;
    assign frame_command = out_reg.command;
    assign frame_length  = out_reg.length;

endmodule

### sv/sfd_checker.sv
// Port-level checks for sync_frame_deframer_crc16, attached by bind.
// Depends on sfd_pkg for the result kinds and status codes, and on the top level's port names.
module sfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic        result_kind,
    input logic [7:0]  payload_byte,
    input logic [1:0]  frame_status,
    input logic [7:0]  frame_command,
    input logic [15:0] frame_length
);
    import sfd_pkg::*;

    // Payload items carry no status
    a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_kind == KIND_PAYLOAD)) |-> (frame_status == ST_OK))
        else $error("payload item with nonzero status");

    // Frame-end items carry a zero payload byte
    a_end_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_kind == KIND_FRAME_END)) |-> (payload_byte == 8'h00))
        else $error("frame-end item with nonzero payload byte");

    // A stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_kind)
            && $stable(payload_byte) && $stable(frame_status)
            && $stable(frame_command) && $stable(frame_length)))
        else $error("stalled item changed");

    // A fresh result follows a byte taken at the input, by way of the input and result registers
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(byte_valid && byte_ready, 2))
        else $error("result without a preceding byte");

endmodule

bind sync_frame_deframer_crc16 sfd_checker u_sfd_checker (.*);
